@@ sv/sebd_pkg.sv @@
// Shared types and constants of the scaler event buffer decoder.
package sebd_pkg;

  localparam int unsigned WORD_BITS      = 32;
  localparam int unsigned INDEX_BITS     = 16;
  localparam int unsigned OLD_COUNT_BITS = 8;
  localparam int unsigned OLD_STAMP_BIT  = 31;
  localparam int unsigned NEW_FORMAT_BIT = 30;
  localparam int unsigned CFG_IDX_BITS   = 2;
  localparam int unsigned CFG_DATA_BITS  = 16;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_NEW_FORMAT  = 2'd0,
    CFG_TIME_TAG_ON = 2'd1,
    CFG_WIDE_MODE   = 2'd2,
    CFG_BASE_INDEX  = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_SKIP  = 4'b0010,
    PH_STAMP = 4'b0100,
    PH_COUNT = 4'b1000
  } phase_t;

  typedef struct packed {
    logic                  new_format;
    logic                  time_tag_on;
    logic                  wide_mode;
    logic [INDEX_BITS-1:0] base_index;
  } cfg_t;

  typedef struct packed {
    logic [INDEX_BITS-1:0] scaler_index;
    logic [WORD_BITS-1:0]  value;
    logic                  is_time;
    logic                  last;
  } res_t;

  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic                 frame_start;
  } item_t;

endpackage

@@ sv/scaler_event_buffer_decoder_core.sv @@
// Top level of the scaler event buffer decoder.
//
// Usage:
//   in_*   : one beat per event buffer word; in_tdata holds the 32-bit word,
//            in_tuser flags the header word that opens a frame.
//   out_*  : one beat per decoded scaler value; out_tdata holds the running
//            scaler index and the passed-through word, out_tuser flags a time
//            stamp, out_tlast marks the final value of a frame.
//   cfg_*  : register writes (format select, time tag enable, wide stamp,
//            base index); always ready, sampled at the next header beat.
// Path: each input beat is held in the input register, then decoded into the
//   result register, from which its result beat is presented.
// Throughput: one input beat per cycle while not stalled; headers, the skipped
//   data-available word and words outside a frame give no output beat.
// Reset: rst_n low clears both stage valids and puts the decoder idle,
//   awaiting a header; registers return to new_format 0, time_tag_on 1,
//   wide_mode 0, base_index 0.
// Stall: while out_tready is low and a result waits, decode holds and the
//   input register fills; in_tready then drops until the result is taken.
module scaler_event_buffer_decoder_core #(
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] word
  input  logic        in_tuser,   // [0] frame_start
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] scaler_index, [47:16] value
  output logic        out_tuser,  // [0] is_time
  output logic        out_tlast,
  // Configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [sebd_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [sebd_pkg::CFG_DATA_BITS-1:0] cfg_data
);

  sebd_pkg::cfg_t  cfg_r;
  sebd_pkg::item_t in_item, item;
  sebd_pkg::res_t  dec_res, out_res;
  logic            item_valid, can_load, fire, emit;

  // Configuration registers; always accept a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.new_format  <= 1'b0;
      cfg_r.time_tag_on <= 1'b1;
      cfg_r.wide_mode   <= 1'b0;
      cfg_r.base_index  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (sebd_pkg::cfg_idx_t'(cfg_index))
        sebd_pkg::CFG_NEW_FORMAT:  cfg_r.new_format  <= cfg_data[0];
        sebd_pkg::CFG_TIME_TAG_ON: cfg_r.time_tag_on <= cfg_data[0];
        sebd_pkg::CFG_WIDE_MODE:   cfg_r.wide_mode   <= cfg_data[0];
        sebd_pkg::CFG_BASE_INDEX:  cfg_r.base_index  <= cfg_data;
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  assign in_item.word        = in_tdata;
  assign in_item.frame_start = in_tuser;

  // Advance the held word whenever the result register can take its outcome.
  assign fire = item_valid && can_load;

  sebd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_item    (in_item),
    .take       (fire),
    .item_valid (item_valid),
    .item       (item)
  );

  sebd_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dec (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg_r),
    .fire  (fire),
    .item  (item),
    .emit  (emit),
    .res   (dec_res)
  );

  sebd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (emit),
    .res        (dec_res),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.value, out_res.scaler_index};
  assign out_tuser = out_res.is_time;
  assign out_tlast = out_res.last;

endmodule

@@ sv/sebd_in_stage.sv @@
// Input register stage of the scaler event buffer decoder.
module sebd_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  sebd_pkg::item_t in_item,
  input  logic           take,
  output logic           item_valid,
  output sebd_pkg::item_t item
);

  logic            valid_r, valid_nxt;
  sebd_pkg::item_t item_r;

  // Free the register when it is empty or drained this cycle.
  assign in_tready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

@@ sv/sebd_decode.sv @@
// Frame state machine and per-word decode of the scaler event buffer decoder.
module sebd_decode #(
  parameter int unsigned COUNT_BITS = 12
) (
  input  logic            clk,
  input  logic            rst_n,
  input  sebd_pkg::cfg_t  cfg,
  input  logic            fire,
  input  sebd_pkg::item_t item,
  output logic            emit,
  output sebd_pkg::res_t  res
);

  localparam int unsigned NB = sebd_pkg::OLD_COUNT_BITS;

  sebd_pkg::phase_t                  phase_r, phase_nxt;
  logic [COUNT_BITS-1:0]             words_left_r, words_left_nxt;
  logic [sebd_pkg::INDEX_BITS-1:0]   next_index_r, next_index_nxt;
  logic [1:0]                        stamp_left_r, stamp_left_nxt;

  logic [NB-1:0]         old_cnt, old_n, old_wl;
  logic                  old_stamp;
  logic [COUNT_BITS-1:0] new_cnt, new_n, new_wl, new_st;
  logic [1:0]            new_stamps;
  logic [1:0]            stamp_dec;
  logic [COUNT_BITS-1:0] words_dec;

  // Header arithmetic, saturating at zero, plus the stamp and word count decrements.
  always_comb begin
    old_cnt   = item.word[NB-1:0];
    old_stamp = item.word[sebd_pkg::OLD_STAMP_BIT];
    old_n     = (old_cnt != '0) ? old_cnt - NB'(1) : '0;
    old_wl    = (old_n > NB'(old_stamp)) ? old_n - NB'(old_stamp) : '0;

    new_cnt    = item.word[COUNT_BITS-1:0];
    new_stamps = cfg.time_tag_on ? (cfg.wide_mode ? 2'd2 : 2'd1) : 2'd0;
    new_st     = COUNT_BITS'(new_stamps);
    new_n      = (new_cnt != '0) ? new_cnt - COUNT_BITS'(1) : '0;
    new_wl     = (new_n > new_st) ? new_n - new_st : '0;

    stamp_dec = stamp_left_r - 2'd1;
    words_dec = words_left_r - COUNT_BITS'(1);
  end

  always_comb begin
    phase_nxt      = phase_r;
    words_left_nxt = words_left_r;
    next_index_nxt = next_index_r;
    stamp_left_nxt = stamp_left_r;
    emit           = 1'b0;
    res.scaler_index = next_index_r;
    res.value        = item.word;
    res.is_time      = 1'b0;
    res.last         = 1'b0;

    if (fire) begin
      if (item.frame_start) begin
        next_index_nxt = cfg.base_index;
        if (!cfg.new_format) begin
          stamp_left_nxt = {1'b0, old_stamp};
          words_left_nxt = COUNT_BITS'(old_wl);
          if (old_stamp) begin
            phase_nxt = sebd_pkg::PH_STAMP;
          end else if (old_wl != '0) begin
            phase_nxt = sebd_pkg::PH_COUNT;
          end else begin
            phase_nxt = sebd_pkg::PH_IDLE;
          end
        end else if (!item.word[sebd_pkg::NEW_FORMAT_BIT]) begin
          // Drop the frame: no new-format mark.
          phase_nxt      = sebd_pkg::PH_IDLE;
          words_left_nxt = '0;
          stamp_left_nxt = '0;
        end else begin
          stamp_left_nxt = new_stamps;
          words_left_nxt = new_wl;
          phase_nxt      = sebd_pkg::PH_SKIP;
        end
      end else begin
        case (phase_r)
          sebd_pkg::PH_SKIP: begin
            if (stamp_left_r != '0) begin
              phase_nxt = sebd_pkg::PH_STAMP;
            end else if (words_left_r != '0) begin
              phase_nxt = sebd_pkg::PH_COUNT;
            end else begin
              phase_nxt = sebd_pkg::PH_IDLE;
            end
          end
          sebd_pkg::PH_STAMP: begin
            stamp_left_nxt = stamp_dec;
            emit           = 1'b1;
            res.is_time    = 1'b1;
            res.last       = (stamp_dec == '0) && (words_left_r == '0);
            next_index_nxt = next_index_r + sebd_pkg::INDEX_BITS'(1);
            if (stamp_dec != '0) begin
              phase_nxt = sebd_pkg::PH_STAMP;
            end else if (words_left_r != '0) begin
              phase_nxt = sebd_pkg::PH_COUNT;
            end else begin
              phase_nxt = sebd_pkg::PH_IDLE;
            end
          end
          sebd_pkg::PH_COUNT: begin
            words_left_nxt = words_dec;
            emit           = 1'b1;
            res.last       = (words_dec == '0);
            next_index_nxt = next_index_r + sebd_pkg::INDEX_BITS'(1);
            if (words_dec == '0) begin
              phase_nxt = sebd_pkg::PH_IDLE;
            end
          end
          default: begin
            phase_nxt = phase_r;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sebd_pkg::PH_IDLE;
      words_left_r <= '0;
      next_index_r <= '0;
      stamp_left_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      words_left_r <= words_left_nxt;
      next_index_r <= next_index_nxt;
      stamp_left_r <= stamp_left_nxt;
    end
  end

  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sebd_pkg::PH_COUNT) |-> (words_left_r != '0))
    else $error("count phase with no words left");

  a_stamp_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == sebd_pkg::PH_STAMP) |-> (stamp_left_r != '0) && (stamp_left_r != 2'd3))
    else $error("stamp phase with bad stamp count");

  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && res.last) |=> (phase_r == sebd_pkg::PH_IDLE))
    else $error("frame continues after last value");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (next_index_r == $past(next_index_r) + sebd_pkg::INDEX_BITS'(1)))
    else $error("scaler index did not advance on emit");

endmodule

@@ sv/sebd_out_stage.sv @@
// Result register stage of the scaler event buffer decoder.
module sebd_out_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load,
  input  sebd_pkg::res_t res,
  output logic           can_load,
  output logic           out_tvalid,
  input  logic           out_tready,
  output sebd_pkg::res_t out_res
);

  logic           valid_r, valid_nxt;
  sebd_pkg::res_t res_r;

  assign can_load = !valid_r || out_tready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_tvalid = valid_r;
  assign out_res    = res_r;

endmodule
